FILE: rtl/core/esd_pkg.sv
// Shared types, character codes and the hex digit decoder of the escape decoder.
`default_nettype none

package esd_pkg;

	// Character codes that steer the decoder.
	localparam logic [7:0] CHAR_BSL = 8'h5C;
	localparam logic [7:0] CHAR_E   = 8'h65;
	localparam logic [7:0] CHAR_R   = 8'h72;
	localparam logic [7:0] CHAR_N   = 8'h6E;
	localparam logic [7:0] CHAR_X   = 8'h78;

	// Bytes produced by the single-letter escapes.
	localparam logic [7:0] BYTE_ESC = 8'h1B;
	localparam logic [7:0] BYTE_CR  = 8'h0D;
	localparam logic [7:0] BYTE_LF  = 8'h0A;

	// Output length counter.
	localparam int unsigned COUNT_W = 16;
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	// Queue between the decoder and the result stage.
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned QUEUE_FILL_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_ESC,
		MODE_HEX1,
		MODE_HEX2,
		MODE_ERR
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BAD_ESC = 2'd1,
		ST_BAD_HEX = 2'd2,
		ST_END     = 2'd3
	} status_t;

	// One classified item handed from the decoder to the result stage.
	typedef struct packed {
		logic [7:0] byte_val;
		logic       produce;
		logic       last;
		status_t    status;
	} op_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] value;
	} hex_t;

	// Value of one hex digit in either case.
	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t h;
		h.ok = 1'b1;
		h.value = 4'd0;
		if (c inside {[8'h30:8'h39]}) begin
			h.value = c[3:0];
		end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
			h.value = 4'(c[2:0] + 3'd1) + 4'd8;
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/esd_if.sv
// Handshake channels for input characters and decoded results.
`default_nettype none

interface esd_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       is_last;

	modport source (output valid, output char_in, output is_last, input ready);
	modport sink (input valid, input char_in, input is_last, output ready);
endinterface

interface esd_result_if;
	logic        valid;
	logic        ready;
	logic [7:0]  byte_out;
	logic        byte_valid;
	logic        done_res;
	logic [1:0]  status;
	logic [15:0] out_length;

	modport source (
		output valid, output byte_out, output byte_valid, output done_res,
		output status, output out_length, input ready
	);
	modport sink (
		input valid, input byte_out, input byte_valid, input done_res,
		input status, input out_length, output ready
	);
endinterface

`default_nettype wire

FILE: rtl/core/esd_front.sv
// Escape state machine: takes characters and classifies each into a decoded item.
`default_nettype none

module esd_front (
	input  wire logic     clk,
	input  wire logic     arst_n,
	esd_char_if.sink      char_ch,
	output esd_pkg::op_t  op,
	output logic          op_valid,
	input  wire logic     op_ready
);
	import esd_pkg::*;

	mode_t      mode_q, mode_n;
	status_t    err_q, err_n;
	logic [3:0] nib_q, nib_n;
	hex_t       hex;
	logic       accept;
	logic [7:0] c;
	logic       last;

	assign c        = char_ch.char_in;
	assign last     = char_ch.is_last;
	assign hex      = hex_decode(c);
	assign op_valid = char_ch.valid;
	assign char_ch.ready = op_ready;
	assign accept   = char_ch.valid && op_ready;

	// Next state of the escape parser before the end-of-string return to idle.
	always_comb begin
		mode_n = mode_q;
		err_n  = err_q;
		nib_n  = nib_q;
		case (mode_q)
			MODE_IDLE: begin
				if (c == CHAR_BSL) begin
					if (last) begin
						err_n  = ST_BAD_ESC;
						mode_n = MODE_ERR;
					end else begin
						mode_n = MODE_ESC;
					end
				end
			end
			MODE_ESC: begin
				if (c == CHAR_E || c == CHAR_R || c == CHAR_N) begin
					mode_n = MODE_IDLE;
				end else if (c == CHAR_X) begin
					if (last) begin
						err_n  = ST_END;
						mode_n = MODE_ERR;
					end else begin
						mode_n = MODE_HEX1;
					end
				end else begin
					err_n  = ST_BAD_ESC;
					mode_n = MODE_ERR;
				end
			end
			MODE_HEX1: begin
				if (last) begin
					err_n  = ST_END;
					mode_n = MODE_ERR;
				end else if (!hex.ok) begin
					err_n  = ST_BAD_HEX;
					mode_n = MODE_ERR;
				end else begin
					nib_n  = hex.value;
					mode_n = MODE_HEX2;
				end
			end
			MODE_HEX2: begin
				if (!hex.ok) begin
					err_n  = ST_BAD_HEX;
					mode_n = MODE_ERR;
				end else begin
					mode_n = MODE_IDLE;
				end
			end
			default: begin
				mode_n = MODE_ERR;
			end
		endcase
	end

	// Decoded byte and end-of-string status for the current item.
	always_comb begin
		op.byte_val = 8'h00;
		op.produce  = 1'b0;
		op.last     = last;
		case (mode_q)
			MODE_IDLE: begin
				if (c != CHAR_BSL) begin
					op.produce  = 1'b1;
					op.byte_val = c;
				end
			end
			MODE_ESC: begin
				if (c == CHAR_E) begin
					op.produce  = 1'b1;
					op.byte_val = BYTE_ESC;
				end else if (c == CHAR_R) begin
					op.produce  = 1'b1;
					op.byte_val = BYTE_CR;
				end else if (c == CHAR_N) begin
					op.produce  = 1'b1;
					op.byte_val = BYTE_LF;
				end
			end
			MODE_HEX2: begin
				if (hex.ok) begin
					op.produce  = 1'b1;
					op.byte_val = {nib_q, hex.value};
				end
			end
			default: begin
				op.produce = 1'b0;
			end
		endcase
		op.status = (last && mode_n == MODE_ERR) ? err_n : ST_OK;
	end

	// Parser state; the last character of a string returns it to idle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			err_q  <= ST_OK;
		end else if (accept) begin
			mode_q <= last ? MODE_IDLE : mode_n;
			err_q  <= last ? ST_OK : err_n;
		end
	end

	// First hex digit.
	always_ff @(posedge clk) begin
		if (accept) begin
			nib_q <= nib_n;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/esd_queue.sv
// Short first-in first-out queue of decoded items between decoder and result stage.
`default_nettype none

module esd_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire esd_pkg::op_t  push_data,
	input  wire logic          push_valid,
	output logic               push_ready,
	output esd_pkg::op_t       pop_data,
	output logic               pop_valid,
	input  wire logic          pop_ready
);
	import esd_pkg::*;

	op_t                     entry_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0]  wr_ptr_q;
	logic [QUEUE_PTR_W-1:0]  rd_ptr_q;
	logic [QUEUE_FILL_W-1:0] fill_q;
	logic                    push;
	logic                    pop;

	assign push_ready = (fill_q != QUEUE_FILL_W'(QUEUE_DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	function automatic logic [QUEUE_PTR_W-1:0] ptr_next(input logic [QUEUE_PTR_W-1:0] p);
		return (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/esd_back.sv
// Result stage: counts produced bytes and holds each result item until it is taken.
`default_nettype none

module esd_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire esd_pkg::op_t  op,
	input  wire logic          op_valid,
	output logic               op_ready,
	esd_result_if.source       result_ch
);
	import esd_pkg::*;

	logic               valid_q;
	logic [7:0]         byte_q;
	logic               byte_valid_q;
	logic               done_q;
	status_t            status_q;
	logic [COUNT_W-1:0] length_q;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] count_inc;
	logic               take;

	assign op_ready = !valid_q || result_ch.ready;
	assign take     = op_valid && op_ready;

	// Saturating byte count including the current item.
	assign count_inc = (op.produce && count_q != COUNT_MAX) ? count_q + 1'b1 : count_q;

	// Output valid and the running count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (take) begin
				valid_q <= 1'b1;
				count_q <= op.last ? '0 : count_inc;
			end else if (result_ch.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (take) begin
			byte_q       <= op.byte_val;
			byte_valid_q <= op.produce;
			done_q       <= op.last;
			status_q     <= op.status;
			length_q     <= (op.last && op.status == ST_OK) ? count_inc : '0;
		end
	end

	assign result_ch.valid      = valid_q;
	assign result_ch.byte_out   = byte_q;
	assign result_ch.byte_valid = byte_valid_q;
	assign result_ch.done_res   = done_q;
	assign result_ch.status     = status_q;
	assign result_ch.out_length = length_q;

endmodule

`default_nettype wire

FILE: rtl/core/escape_sequence_decoder_unit.sv
// Top level of the backslash escape decoder.
// The unit takes one character item per clock while the queue has room, and returns exactly
// one result item per character, in order: a decoded byte when one is produced, and on the
// last character of a string the status and the decoded length (saturating at 65535, zero
// on error). The escape state machine decodes a character combinationally in the accept
// cycle and writes the item into a two-entry queue; the result stage registers the item
// when it leaves the queue. The queue and the output register let the input keep flowing
// for up to three items while the result side stalls. There is no clearing pass after
// reset.
`default_nettype none

module escape_sequence_decoder_unit (
	input  wire logic     clk,
	input  wire logic     arst_n,
	esd_char_if.sink      char_ch,
	esd_result_if.source  result_ch
);
	import esd_pkg::*;

	op_t  front_op;
	logic front_valid;
	logic front_ready;
	op_t  back_op;
	logic back_valid;
	logic back_ready;

	esd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.char_ch  (char_ch),
		.op       (front_op),
		.op_valid (front_valid),
		.op_ready (front_ready)
	);

	esd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_data  (front_op),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.pop_data   (back_op),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready)
	);

	esd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (back_op),
		.op_valid  (back_valid),
		.op_ready  (back_ready),
		.result_ch (result_ch)
	);

	// A full queue always has an item to hand on.
	a_full_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		!front_ready |-> back_valid)
		else $error("queue refuses items while empty");

	// Only an end-of-string result carries a status or a length.
	a_mid_string_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(result_ch.valid && !result_ch.done_res) |->
		(result_ch.status == ST_OK && result_ch.out_length == 16'd0))
		else $error("status or length on a result that is not the last");

	// A failed string reports no length.
	a_error_no_length: assert property (@(posedge clk) disable iff (!arst_n)
		(result_ch.valid && result_ch.status != ST_OK) |-> result_ch.out_length == 16'd0)
		else $error("length reported with an error status");

	// A result without a byte carries a zero byte.
	a_no_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_ch.valid && !result_ch.byte_valid) |-> result_ch.byte_out == 8'h00)
		else $error("nonzero byte on a result without a byte");

endmodule

`default_nettype wire
